// ===== rtl/expression_tokenizer_macros.svh =====
// Assertion macros shared by the expression tokenizer RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef EXPRESSION_TOKENIZER_MACROS_SVH
`define EXPRESSION_TOKENIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define ET_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tokenizer same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define ET_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tokenizer next-cycle check failed");

`endif

// ===== rtl/et_pkg.sv =====
// Package for the expression tokenizer: token kinds, result item type,
// character codes and default parameter values. No dependencies.
`timescale 1ns / 1ps

package et_pkg;

	// Parameter defaults
	localparam int ET_MAX_LEN_DEFAULT  = 255;
	localparam int ET_POS_BITS_DEFAULT = 16;

	// Result queue depth (power of two)
	localparam int ET_FIFO_DEPTH = 4;

	// Token kinds
	typedef enum logic [3:0] {
		KIND_ADD     = 4'd0,
		KIND_SUB     = 4'd1,
		KIND_MUL     = 4'd2,
		KIND_DIV     = 4'd3,
		KIND_LPAREN  = 4'd4,
		KIND_RPAREN  = 4'd5,
		KIND_EQUALS  = 4'd6,
		KIND_SEMI    = 4'd7,
		KIND_INT     = 4'd8,
		KIND_NAME    = 4'd9,
		KIND_ILLEGAL = 4'd10
	} et_kind_t;

	// Character codes
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_EQUALS = 8'h3D;
	localparam logic [7:0] CH_UPPER_LO = 8'd64;  // exclusive bounds of A-Z
	localparam logic [7:0] CH_UPPER_HI = 8'd91;
	localparam logic [7:0] CH_LOWER_LO = 8'd96;  // exclusive bounds of a-z
	localparam logic [7:0] CH_LOWER_HI = 8'd123;
	localparam logic [7:0] CH_USCORE = 8'h5F;

	// One result item
	typedef struct packed {
		et_kind_t    kind;
		logic [15:0] start_pos;
		logic [7:0]  lexeme_len;
		logic        too_long;
		logic [7:0]  char_code;
		logic        last;
	} et_result_t;

	// Up to two result items handed from the lexer to the queue per cycle
	typedef struct packed {
		logic [1:0] count;
		et_result_t r0;
		et_result_t r1;
	} et_push_t;

endpackage

// ===== rtl/et_lexer.sv =====
// Input register and lexer state update for the expression tokenizer.
// Depends on et_pkg and expression_tokenizer_macros.svh.
`timescale 1ns / 1ps
`include "expression_tokenizer_macros.svh"

module et_lexer #(
	parameter int MAX_LEN  = et_pkg::ET_MAX_LEN_DEFAULT,
	parameter int POS_BITS = et_pkg::ET_POS_BITS_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] ch
	input  logic             s_tlast,   // end_of_text
	input  logic             room,      // queue can take two items
	output et_pkg::et_push_t push
);

	localparam logic [7:0] LenCap = (MAX_LEN > 255) ? 8'd255 : 8'(MAX_LEN);

	typedef enum logic [2:0] {
		MODE_NONE = 3'b001,
		MODE_INT  = 3'b010,
		MODE_NAME = 3'b100
	} mode_t;

	// Input register
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eot_s1;

	// Lexer state
	mode_t               mode_q;
	logic [POS_BITS-1:0] pend_start_q;
	logic [7:0]          pend_len_q;
	logic                pend_over_q;
	logic [POS_BITS-1:0] text_pos_q;

	logic adv;
	logic end_text, is_digit, is_letter, is_uscore, is_blank, is_single, cont;
	logic pend_v, flush_v, tok_v;
	et_pkg::et_kind_t    single_kind;
	et_pkg::et_result_t  flush_r, tok_r;
	logic [POS_BITS+15:0] pstart_ext, pos_ext;

	assign adv      = valid_s1 && room;
	assign s_tready = !valid_s1 || adv;

	// Input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input register payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			ch_s1  <= s_tdata;
			eot_s1 <= s_tlast;
		end
	end

	// Byte classes
	assign end_text  = eot_s1 || (ch_s1 == et_pkg::CH_NUL);
	assign is_digit  = (ch_s1 >= et_pkg::CH_0) && (ch_s1 <= et_pkg::CH_9);
	assign is_letter = ((ch_s1 > et_pkg::CH_UPPER_LO) && (ch_s1 < et_pkg::CH_UPPER_HI)) ||
	                   ((ch_s1 > et_pkg::CH_LOWER_LO) && (ch_s1 < et_pkg::CH_LOWER_HI));
	assign is_uscore = (ch_s1 == et_pkg::CH_USCORE);
	assign is_blank  = (ch_s1 == et_pkg::CH_SPACE) || (ch_s1 == et_pkg::CH_TAB) ||
	                   (ch_s1 == et_pkg::CH_LF);

	always_comb begin
		is_single   = 1'b1;
		single_kind = et_pkg::KIND_ILLEGAL;
		case (ch_s1)
			et_pkg::CH_PLUS:   single_kind = et_pkg::KIND_ADD;
			et_pkg::CH_MINUS:  single_kind = et_pkg::KIND_SUB;
			et_pkg::CH_STAR:   single_kind = et_pkg::KIND_MUL;
			et_pkg::CH_SLASH:  single_kind = et_pkg::KIND_DIV;
			et_pkg::CH_LPAREN: single_kind = et_pkg::KIND_LPAREN;
			et_pkg::CH_RPAREN: single_kind = et_pkg::KIND_RPAREN;
			et_pkg::CH_EQUALS: single_kind = et_pkg::KIND_EQUALS;
			et_pkg::CH_SEMI:   single_kind = et_pkg::KIND_SEMI;
			default:           is_single   = 1'b0;
		endcase
	end

	// Pending lexeme continues with this byte
	assign pend_v = (mode_q == MODE_INT) || (mode_q == MODE_NAME);
	assign cont   = !end_text &&
	                (((mode_q == MODE_INT) && is_digit) ||
	                 ((mode_q == MODE_NAME) && (is_letter || is_digit || is_uscore)));

	assign flush_v = pend_v && !cont;
	assign tok_v   = !end_text && !cont && !is_blank && !is_digit && !is_letter && !is_uscore;

	// Positions reported on 16 bits: low bits, zero-extended when narrower
	assign pstart_ext = {16'b0, pend_start_q};
	assign pos_ext    = {16'b0, text_pos_q};

	always_comb begin
		flush_r.kind       = (mode_q == MODE_INT) ? et_pkg::KIND_INT : et_pkg::KIND_NAME;
		flush_r.start_pos  = pstart_ext[15:0];
		flush_r.lexeme_len = pend_len_q;
		flush_r.too_long   = pend_over_q;
		flush_r.char_code  = 8'd0;
		flush_r.last       = 1'b0;

		tok_r.kind       = is_single ? single_kind : et_pkg::KIND_ILLEGAL;
		tok_r.start_pos  = pos_ext[15:0];
		tok_r.lexeme_len = 8'd1;
		tok_r.too_long   = 1'b0;
		tok_r.char_code  = ch_s1;
		tok_r.last       = 1'b0;
	end

	// Compact results: a flushed lexeme goes first, last marks the final one
	always_comb begin
		push.count = 2'd0;
		push.r0    = flush_v ? flush_r : tok_r;
		push.r1    = tok_r;
		if (flush_v && tok_v) begin
			push.r1.last = 1'b1;
		end else begin
			push.r0.last = 1'b1;
		end
		if (adv) begin
			push.count = {1'b0, flush_v} + {1'b0, tok_v};
		end
	end

	// Lexer state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_NONE;
			pend_start_q <= '0;
			pend_len_q   <= 8'd0;
			pend_over_q  <= 1'b0;
			text_pos_q   <= '0;
		end else if (adv) begin
			if (end_text) begin
				mode_q       <= MODE_NONE;
				pend_start_q <= '0;
				pend_len_q   <= 8'd0;
				pend_over_q  <= 1'b0;
				text_pos_q   <= '0;
			end else begin
				text_pos_q <= text_pos_q + POS_BITS'(1);
				if (cont) begin
					if (pend_len_q < LenCap) begin
						pend_len_q <= pend_len_q + 8'd1;
					end else begin
						pend_over_q <= 1'b1;
					end
				end else if (is_digit || is_letter || is_uscore) begin
					mode_q       <= is_digit ? MODE_INT : MODE_NAME;
					pend_start_q <= text_pos_q;
					pend_len_q   <= 8'd1;
					pend_over_q  <= 1'b0;
				end else begin
					mode_q       <= MODE_NONE;
					pend_start_q <= '0;
					pend_len_q   <= 8'd0;
					pend_over_q  <= 1'b0;
				end
			end
		end
	end

	// Checks
	`ET_ASSERT_NEXT(a_eot_pos_clear, clk, arst_n, adv && end_text, text_pos_q == '0)
	`ET_ASSERT_SAME(a_pend_len_nonzero, clk, arst_n, pend_v, pend_len_q != 8'd0)
	`ET_ASSERT_SAME(a_over_at_cap, clk, arst_n, pend_over_q, pend_len_q == LenCap)

endmodule

// ===== rtl/et_result_fifo.sv =====
// Result queue of the expression tokenizer: takes up to two items a cycle,
// delivers one per handshake. Depends on et_pkg and the assertion macros.
`timescale 1ns / 1ps
`include "expression_tokenizer_macros.svh"

module et_result_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  et_pkg::et_push_t    push,
	output logic                room,
	output logic                m_tvalid,
	input  logic                m_tready,
	output et_pkg::et_result_t  head
);

	localparam int Depth   = et_pkg::ET_FIFO_DEPTH;
	localparam int PtrBits = $clog2(Depth);
	localparam int CntBits = $clog2(Depth + 1);

	et_pkg::et_result_t mem_q [Depth];
	logic [PtrBits-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntBits-1:0] count_q;
	logic               pop;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (count_q != '0);
	assign room     = (count_q <= CntBits'(Depth - 2));
	assign head     = mem_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PtrBits'(push.count);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PtrBits'(1);
			end
			count_q <= count_q + CntBits'(push.count) - CntBits'(pop);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + PtrBits'(1)] <= push.r1;
		end
	end

	// Checks
	`ET_ASSERT_SAME(a_no_overflow, clk, arst_n, 1'b1, count_q <= CntBits'(Depth))
	`ET_ASSERT_SAME(a_push_needs_room, clk, arst_n, push.count != 2'd0, room)
	`ET_ASSERT_NEXT(a_pop_drains_one, clk, arst_n, pop && (push.count == 2'd0), count_q == CntBits'($past(count_q) - CntBits'(1)))

endmodule

// ===== rtl/expression_tokenizer.sv =====
// A result passes through the input register and the result queue before it is
// offered; the second item of a pair follows it. Throughput: one byte per cycle;
// a byte that ends a pending INT or NAME and also gives its own token yields two
// items, delivered one per cycle while m_tready is high through a four-entry result
// queue, which holds input whenever it has fewer than two free slots.
// Reset (arst_n low, asynchronous): no lexeme pending, text position 0, queue empty.
`timescale 1ns / 1ps

module expression_tokenizer #(
	parameter int MAX_LEN  = et_pkg::ET_MAX_LEN_DEFAULT,
	parameter int POS_BITS = et_pkg::ET_POS_BITS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] ch
	input  logic        s_tlast,   // end_of_text
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // start_pos[15:0], lexeme_len[23:16], too_long[24],
	                               // char_code[32:25], zero[39:33]
	output logic [3:0]  m_tuser,   // kind[3:0]
	output logic        m_tlast    // last
);

	et_pkg::et_push_t   push;
	et_pkg::et_result_t head;
	logic               room;

	et_lexer #(
		.MAX_LEN  (MAX_LEN),
		.POS_BITS (POS_BITS)
	) u_lexer (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.room     (room),
		.push     (push)
	);

	et_result_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.room     (room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.head     (head)
	);

	// Output packing
	assign m_tdata = {7'b0000000, head.char_code, head.too_long, head.lexeme_len,
	                  head.start_pos};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule
